/* hdl/apool_pkg.sv */
// Package: shared types and constants for the average pooling block.
`default_nettype none
package apool_pkg;
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DRAIN,
    ST_DIV,
    ST_DONE
  } apool_state_e;

  localparam int unsigned RegIdxW = 3;
  localparam int unsigned CfgDataW = 7;

  localparam logic [RegIdxW-1:0] REG_IN_WIDTH      = 3'd0;
  localparam logic [RegIdxW-1:0] REG_IN_HEIGHT     = 3'd1;
  localparam logic [RegIdxW-1:0] REG_WINDOW_WIDTH  = 3'd2;
  localparam logic [RegIdxW-1:0] REG_WINDOW_HEIGHT = 3'd3;
  localparam logic [RegIdxW-1:0] REG_STRIDE_HORIZ  = 3'd4;
  localparam logic [RegIdxW-1:0] REG_STRIDE_VERT   = 3'd5;
  localparam logic [RegIdxW-1:0] REG_PAD_ABOVE     = 3'd6;
  localparam logic [RegIdxW-1:0] REG_PAD_BEFORE    = 3'd7;

  localparam logic OP_LOAD  = 1'b0;
  localparam logic OP_QUERY = 1'b1;
endpackage
`default_nettype wire

/* hdl/apool_ram.sv */
// Generic RAM with one write port and one registered read port.
`default_nettype none
module apool_ram #(
  parameter int unsigned Width = 16,
  parameter int unsigned Depth = 4096
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output logic      [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end
endmodule
`default_nettype wire

/* hdl/apool_div.sv */
// Iterative signed divide of the window sum by the tap count.
`default_nettype none
module apool_div #(
  parameter int unsigned SumW = 23,
  parameter int unsigned CntW = 7
) (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire logic                   start_i,
  input  wire logic signed [SumW-1:0] sum_i,
  input  wire logic [CntW-1:0]        cnt_i,
  output logic                        done_o,
  output logic signed [15:0]          quot_o
);
  localparam int unsigned StepW = $clog2(SumW + 1);

  logic [SumW-1:0] rem_q, rem_d, quo_q, quo_d;
  logic [CntW-1:0] dvs_q;
  logic            neg_q, run_q;
  logic [StepW-1:0] step_q;
  logic [SumW:0]   trial;
  logic [SumW-1:0] neg_quo;

  // restoring division, one quotient bit per cycle on magnitudes
  always_comb begin
    trial = {rem_q, quo_q[SumW-1]};
    rem_d = trial[SumW-1:0];
    quo_d = {quo_q[SumW-2:0], 1'b0};
    if (trial >= {{(SumW+1-CntW){1'b0}}, dvs_q}) begin
      rem_d    = SumW'(trial - {{(SumW+1-CntW){1'b0}}, dvs_q});
      quo_d[0] = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      step_q <= '0;
      done_o <= 1'b0;
    end else begin
      done_o <= 1'b0;
      if (start_i) begin
        run_q  <= 1'b1;
        step_q <= StepW'(SumW);
      end else if (run_q) begin
        step_q <= step_q - 1'b1;
        if (step_q == StepW'(1)) begin
          run_q  <= 1'b0;
          done_o <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= '0;
      quo_q <= sum_i[SumW-1] ? SumW'(-sum_i) : sum_i;
      dvs_q <= cnt_i;
      neg_q <= sum_i[SumW-1];
    end else if (run_q) begin
      rem_q <= rem_d;
      quo_q <= quo_d;
    end
  end

  assign neg_quo = neg_q ? SumW'(-quo_q) : quo_q;
  assign quot_o  = neg_quo[15:0];
endmodule
`default_nettype wire

/* hdl/avg_pool_2d_padded_top.sv */
// Top level: buffered-plane 2D average pooling, padding excluded from the mean.
// Load request: written at its accept edge, no result, busy stays low.
// Query request: busy through the scan, one tap per cycle off the single buffer
// read port, then drain, divider setup and the divider run; the divider is skipped
// when no tap is inside. done_o is registered and rises with the result registers.
// Receiver cannot stall. Reset clears control and configuration, not the buffer.
`default_nettype none
module avg_pool_2d_padded_top
  import apool_pkg::*;
#(
  parameter int unsigned MAX_WIDTH  = 64,
  parameter int unsigned MAX_HEIGHT = 64,
  parameter int unsigned MAX_WINDOW = 8
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                start,
  output logic                     busy,
  input  wire logic                cfg_we_i,
  input  wire logic [RegIdxW-1:0]  cfg_idx_i,
  input  wire logic [CfgDataW-1:0] cfg_data_i,
  input  wire logic                op_i,
  input  wire logic [5:0]          row_i,
  input  wire logic [5:0]          col_i,
  input  wire logic signed [15:0]  pixel_i,
  output logic                     done_o,
  output logic signed [15:0]       average_o,
  output logic [6:0]               tap_count_o,
  output logic                     empty_window_o
);
  localparam int unsigned XW   = $clog2(MAX_WIDTH);
  localparam int unsigned YW   = $clog2(MAX_HEIGHT);
  localparam int unsigned AW   = (XW + YW > 0) ? XW + YW : 1;
  localparam int unsigned Deep = MAX_WIDTH * MAX_HEIGHT;
  localparam int unsigned WinW = $clog2(MAX_WINDOW + 1);
  // position math: row*stride up to 63*15, minus pad; signed 12 bits is plenty
  localparam int unsigned PW   = 12;
  localparam int unsigned CntW = 2 * WinW + 1;
  localparam int unsigned SumW = 16 + CntW;

  // configuration registers
  logic [6:0] in_width_q, in_height_q;
  logic [3:0] win_w_q, win_h_q, str_h_q, str_v_q;
  logic [2:0] pad_a_q, pad_b_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_width_q  <= 7'd64;
      in_height_q <= 7'd64;
      win_w_q     <= 4'd2;
      win_h_q     <= 4'd2;
      str_h_q     <= 4'd2;
      str_v_q     <= 4'd2;
      pad_a_q     <= 3'd0;
      pad_b_q     <= 3'd0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_IN_WIDTH:      in_width_q  <= cfg_data_i;
        REG_IN_HEIGHT:     in_height_q <= cfg_data_i;
        REG_WINDOW_WIDTH:  win_w_q     <= cfg_data_i[3:0];
        REG_WINDOW_HEIGHT: win_h_q     <= cfg_data_i[3:0];
        REG_STRIDE_HORIZ:  str_h_q     <= cfg_data_i[3:0];
        REG_STRIDE_VERT:   str_v_q     <= cfg_data_i[3:0];
        REG_PAD_ABOVE:     pad_a_q     <= cfg_data_i[2:0];
        REG_PAD_BEFORE:    pad_b_q     <= cfg_data_i[2:0];
        default: ;
      endcase
    end
  end

  // clamped sizes (signed compare domain)
  logic signed [PW-1:0] w_lim, h_lim;
  logic [WinW-1:0]      ww, wh;
  always_comb begin
    w_lim = (32'(in_width_q) > MAX_WIDTH) ? PW'(MAX_WIDTH) : PW'(in_width_q);
    h_lim = (32'(in_height_q) > MAX_HEIGHT) ? PW'(MAX_HEIGHT) : PW'(in_height_q);
    ww = (32'(win_w_q) > MAX_WINDOW) ? WinW'(MAX_WINDOW) : WinW'(win_w_q);
    wh = (32'(win_h_q) > MAX_WINDOW) ? WinW'(MAX_WINDOW) : WinW'(win_h_q);
  end

  apool_state_e state_q, state_d;
  logic signed [PW-1:0] r0_q, c0_q;
  logic [WinW-1:0]      p_q, q_q;
  logic signed [SumW-1:0] sum_q;
  logic [CntW-1:0]      cnt_q;
  logic                 tap_q;  // a read issued last cycle is inside the image

  logic signed [PW-1:0] r_cur, c_cur;
  logic                 in_img, last_tap, accept;
  logic                 ram_we;
  logic [AW-1:0]        ram_waddr, ram_raddr;
  logic [15:0]          ram_rdata;
  logic                 div_start, div_done;
  logic signed [15:0]   div_quot;

  assign accept = start && !busy;
  assign r_cur  = r0_q + PW'(p_q);
  assign c_cur  = c0_q + PW'(q_q);
  assign in_img = (r_cur >= 0) && (r_cur < h_lim) && (c_cur >= 0) && (c_cur < w_lim);
  assign last_tap = (PW'(p_q) + 1 >= PW'(wh)) && (PW'(q_q) + 1 >= PW'(ww));

  // loads beyond the buffer bounds are dropped
  assign ram_we = accept && (op_i == OP_LOAD) && (32'(row_i) < MAX_HEIGHT)
                  && (32'(col_i) < MAX_WIDTH);
  assign ram_waddr = AW'((32'(row_i) * MAX_WIDTH) + 32'(col_i));
  assign ram_raddr = AW'((32'(r_cur[YW:0]) * MAX_WIDTH) + 32'(c_cur[XW:0]));

  apool_ram #(.Width(16), .Depth(Deep)) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (pixel_i),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  always_comb begin
    state_d   = state_q;
    div_start = 1'b0;
    busy      = (state_q != ST_IDLE);
    case (state_q)
      ST_IDLE:  if (accept && op_i == OP_QUERY) state_d = ST_SCAN;
      ST_SCAN:  if (ww == '0 || wh == '0 || last_tap) state_d = ST_DRAIN;
      ST_DRAIN: begin
        // last tap's data accumulates this cycle; divide next
        state_d = ST_DIV;
      end
      ST_DIV: begin
        if (cnt_q == '0) begin
          state_d = ST_DONE;
        end else begin
          div_start = 1'b1;
          state_d   = ST_DONE;
        end
      end
      ST_DONE: if (cnt_q == '0 || div_done) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  apool_div #(.SumW(SumW), .CntW(CntW)) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .sum_i   (sum_q),
    .cnt_i   (cnt_q),
    .done_o  (div_done),
    .quot_o  (div_quot)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      tap_q   <= 1'b0;
      done_o  <= 1'b0;
    end else begin
      state_q <= state_d;
      tap_q   <= (state_q == ST_SCAN) && in_img && ww != '0 && wh != '0;
      done_o  <= (state_q == ST_DONE) && (cnt_q == '0 || div_done);
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept && op_i == OP_QUERY) begin
      r0_q  <= PW'(32'(row_i) * 32'(str_v_q)) - PW'(pad_a_q);
      c0_q  <= PW'(32'(col_i) * 32'(str_h_q)) - PW'(pad_b_q);
      p_q   <= '0;
      q_q   <= '0;
      sum_q <= '0;
      cnt_q <= '0;
    end else begin
      if (state_q == ST_SCAN) begin
        if (PW'(q_q) + 1 >= PW'(ww)) begin
          q_q <= '0;
          p_q <= p_q + 1'b1;
        end else begin
          q_q <= q_q + 1'b1;
        end
      end
      if (tap_q) begin
        sum_q <= sum_q + SumW'(signed'(ram_rdata));
        cnt_q <= cnt_q + 1'b1;
      end
    end
    if (state_q == ST_DONE && (cnt_q == '0 || div_done)) begin
      average_o      <= (cnt_q == '0) ? 16'sd0 : div_quot;
      tap_count_o    <= 7'(cnt_q);
      empty_window_o <= (cnt_q == '0);
    end
  end
endmodule
`default_nettype wire
